// ----- hdl/fpam_pkg.sv -----
// ----------------------------------------------------------------------------
// fpam_pkg
// Shared types and constants for the special-case single-precision add/min unit
// ----------------------------------------------------------------------------
`default_nettype none

package fpam_pkg;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
   localparam logic [31:0] MANT_MASK = 32'h007F_FFFF;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
   localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

   typedef struct packed {
      logic [31:0] a_bits;
      logic [31:0] b_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] sum_bits;
      logic [31:0] min_bits;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/fp32_special_case_add_and_min_unit.sv -----
// throughput: one request per cycle, sustained while rsp_ready stays high
// four register stages: align, add, normalize, round/pack; the 33-bit
// add and the leading-one shift set the stage depth
// reset: synchronous, active high; clears the stage valid bits only
// ----------------------------------------------------------------------------
// fp32_special_case_add_and_min_unit
// Pipelined single-precision special-case adder and sign-magnitude minimum
// ----------------------------------------------------------------------------
`default_nettype none

module fp32_special_case_add_and_min_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  fpam_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output fpam_pkg::rsp_type        rsp_data
);
   import fpam_pkg::*;

   // global stall: every stage advances when the last one can drain
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: classify, swap, align ----------------
   logic        v1_ff;
   logic        spec1_ff, spec1_in;      // sum decided by a special rule
   logic [31:0] sres1_ff, sres1_in;
   logic [31:0] min1_ff, min1_in;
   logic        sign1_ff, sub1_ff;
   logic [7:0]  e1_ff;
   logic [31:0] mb1_ff, ms1_ff;

   logic [31:0] a, b, big, sml, msh;
   logic [7:0]  ea, eb, es, eb_big;
   logic [7:0]  d;
   logic        a_nan, b_nan, sticky;
   logic [63:0] shx;

   always_comb begin
      a      = req_data.a_bits;
      b      = req_data.b_bits;
      ea     = a[30:23];
      eb     = b[30:23];
      big    = (b[30:0] > a[30:0]) ? b : a;
      sml    = (b[30:0] > a[30:0]) ? a : b;
      eb_big = big[30:23];
      es     = sml[30:23];
      d      = eb_big - es;
      shx    = {1'b1, sml[22:0], 8'h00, 32'h0} >> d;
      sticky = (shx[31:0] != 32'h0);
      if (d >= 8'd40) begin
         msh = 32'd1;
      end else begin
         msh = shx[63:32] | {31'h0, sticky};
      end
      priority if (a[30:0] == 31'h0 || b[30:0] == 31'h0) begin
         spec1_in = 1'b1; sres1_in = POS_ZERO;
      end else if (ea == 8'hFF || eb == 8'hFF) begin
         spec1_in = 1'b1; sres1_in = QNAN_BITS;
      end else if (ea == 8'h00) begin
         spec1_in = 1'b1; sres1_in = (eb != 8'h00) ? b : POS_ZERO;
      end else if (eb == 8'h00) begin
         spec1_in = 1'b1; sres1_in = a;
      end else begin
         spec1_in = 1'b0; sres1_in = POS_ZERO;
      end
      a_nan = (ea == 8'hFF) && (a[22:0] != 23'h0);
      b_nan = (eb == 8'hFF) && (b[22:0] != 23'h0);
      priority if (a_nan || b_nan) begin
         min1_in = QNAN_BITS;
      end else if (a[31] && !b[31]) begin
         min1_in = a;
      end else if (!a[31] && b[31]) begin
         min1_in = b;
      end else if (!a[31]) begin
         min1_in = (a < b) ? a : b;
      end else begin
         min1_in = (a < b) ? b : a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         spec1_ff <= spec1_in;
         sres1_ff <= sres1_in;
         min1_ff  <= min1_in;
         sign1_ff <= big[31];
         sub1_ff  <= a[31] != b[31];
         e1_ff    <= eb_big;
         mb1_ff   <= {1'b1, big[22:0], 8'h00};
         ms1_ff   <= msh;
      end
   end

   // ---------------- stage 2: add / subtract ----------------
   logic        v2_ff, spec2_ff, sign2_ff;
   logic [31:0] sres2_ff, min2_ff;
   logic [8:0]  e2_ff;
   logic [32:0] r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         spec2_ff <= spec1_ff;
         sres2_ff <= sres1_ff;
         min2_ff  <= min1_ff;
         sign2_ff <= sign1_ff;
         e2_ff    <= {1'b0, e1_ff};
         r2_ff    <= sub1_ff ? ({1'b0, mb1_ff} - {1'b0, ms1_ff})
                             : ({1'b0, mb1_ff} + {1'b0, ms1_ff});
      end
   end

   // ---------------- stage 3: normalize ----------------
   logic        v3_ff, spec3_ff, sign3_ff, zero3_ff;
   logic [31:0] sres3_ff, min3_ff, r3_ff;
   logic [8:0]  e3_ff;

   logic [31:0] rn, rsh;
   logic [8:0]  en;
   logic [5:0]  lz, sh;

   always_comb begin
      if (r2_ff[32]) begin
         rn = r2_ff[32:1] | {31'h0, r2_ff[0]};
         en = e2_ff + 9'd1;
      end else begin
         rn = r2_ff[31:0];
         en = e2_ff;
      end
      lz = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (rn[i]) lz = 6'(31 - i);
      end
      // stop when the exponent reaches one, keeping subnormal sums
      if ({3'b0, lz} > en - 9'd1) begin
         sh = 6'(en - 9'd1);
      end else begin
         sh = lz;
      end
      rsh = rn << sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         spec3_ff <= spec2_ff;
         sres3_ff <= sres2_ff;
         min3_ff  <= min2_ff;
         sign3_ff <= sign2_ff;
         zero3_ff <= (r2_ff == 33'h0);
         r3_ff    <= rsh;
         e3_ff    <= en - {3'b0, sh};
      end
   end

   // ---------------- stage 4: round and pack ----------------
   logic        v4_ff;
   rsp_type     out4_ff;
   logic [24:0] keep;
   logic [32:0] total;
   logic [31:0] sum4;

   always_comb begin
      keep = {1'b0, r3_ff[31:8]};
      if (r3_ff[7:0] > 8'h80 || (r3_ff[7:0] == 8'h80 && r3_ff[8])) begin
         keep = keep + 25'd1;
      end
      // rounding carry ripples into the exponent field
      total = {1'b0, e3_ff - 9'd1, 23'h0} + {8'h0, keep};
      if (total >= {1'b0, EXP_MASK}) begin
         total = {1'b0, EXP_MASK};
      end
      if (spec3_ff) begin
         sum4 = sres3_ff;
      end else if (zero3_ff) begin
         sum4 = POS_ZERO;
      end else begin
         sum4 = {sign3_ff, total[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         out4_ff.sum_bits <= sum4;
         out4_ff.min_bits <= min3_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = out4_ff;

   // ---------------- assertions ----------------
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");
   a_ready_tracks: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready out of step with output stage");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##4 (rsp_valid || $past(!adv, 1) ||
       $past(!adv, 2) || $past(!adv, 3)))
      else $error("accepted request did not reach the output");
   a_special_sum: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && adv && spec3_ff) |=> (rsp_data.sum_bits == $past(sres3_ff)))
      else $error("special-case sum not passed through");

endmodule

`default_nettype wire

// ----- bench/tb_fp32_special_case_add_and_min_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fp32_special_case_add_and_min_unit
// Streams operand pairs through the add/min unit: a directed table of special
// operands, then random pairs biased toward normals and edge exponents. Every
// response is compared with an in-bench predictor of the sum and the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fp32_special_case_add_and_min_unit;
   import fpam_pkg::*;

   localparam int NUM_RANDOM = 500;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PIPE_DEPTH = 4;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;

   rsp_type expected_rsp_q[$];
   int error_count = 0;
   int rsp_count = 0;
   int cycle_count = 0;
   bit hold_off_now = 0;
   bit stim_done = 0;

   fp32_special_case_add_and_min_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---- predictor ----
   function automatic logic [31:0] add_normals(logic [31:0] a, logic [31:0] b);
      logic [31:0] big, lil, total32;
      logic [63:0] mb, ms, r, keep, rem, total;
      int e, es, d;
      big = a; lil = b;
      if (b[30:0] > a[30:0]) begin
         big = b; lil = a;
      end
      e = big[30:23];
      es = lil[30:23];
      mb = {32'd0, 9'd1, big[22:0]} << 8;
      ms = {32'd0, 9'd1, lil[22:0]} << 8;
      d = e - es;
      if (d >= 40) ms = 64'd1;
      else if (d > 0) ms = (ms >> d) | ((ms & ((64'd1 << d) - 1)) != 0);
      if (a[31] == b[31]) r = mb + ms;
      else r = mb - ms;
      if (r == 0) return POS_ZERO;
      if (r >= (64'd1 << 32)) begin
         r = (r >> 1) | (r & 1);
         e++;
      end
      while (r[31] == 1'b0 && e > 1) begin
         r = r << 1;
         e--;
      end
      keep = r >> 8;
      rem = r & 64'hFF;
      if (rem > 64'h80 || (rem == 64'h80 && keep[0])) keep++;
      total = ({32'd0, 32'(e - 1)} << 23) + keep;
      if (total >= {32'd0, EXP_MASK}) total = {32'd0, EXP_MASK};
      total32 = total[31:0];
      return (big & SIGN_MASK) | total32;
   endfunction

   function automatic logic [31:0] special_sum(logic [31:0] a, logic [31:0] b);
      if (a[30:0] == 0 || b[30:0] == 0) return POS_ZERO;
      if ((a & EXP_MASK) == EXP_MASK || (b & EXP_MASK) == EXP_MASK) return QNAN_BITS;
      if (a[30:23] == 0) return (b[30:23] != 0) ? b : POS_ZERO;
      if (b[30:23] == 0) return a;
      return add_normals(a, b);
   endfunction

   function automatic bit is_nan(logic [31:0] x);
      return (x & EXP_MASK) == EXP_MASK && (x & MANT_MASK) != 0;
   endfunction

   function automatic logic [31:0] signed_min(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return QNAN_BITS;
      if (a[31] && !b[31]) return a;
      if (!a[31] && b[31]) return b;
      if (!a[31]) return (a < b) ? a : b;
      return (a < b) ? b : a;
   endfunction

   function automatic rsp_type predict_rsp(req_type rq);
      rsp_type p;
      p.sum_bits = special_sum(rq.a_bits, rq.b_bits);
      p.min_bits = signed_min(rq.a_bits, rq.b_bits);
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s at cycle %0d: got %08h want %08h", what, cycle_count, got, want);
      error_count++;
   endtask

   // ---- response side ----
   initial begin
      int gap;
      rsp_ready <= 0;
      @(posedge clock iff !reset);
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) gap = 0;
         repeat (gap) begin
            rsp_ready <= 0;
            @(posedge clock);
         end
         while (hold_off_now) begin
            rsp_ready <= 0;
            @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type want;
         rsp_count++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.sum_bits, 32'h0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.sum_bits !== want.sum_bits)
               report_mismatch("sum_bits", rsp_data.sum_bits, want.sum_bits);
            if (rsp_data.min_bits !== want.min_bits)
               report_mismatch("min_bits", rsp_data.min_bits, want.min_bits);
         end
      end
   end

   // long receiver hold-off, counted in its own process
   initial begin
      @(posedge clock iff !reset);
      repeat (300) @(posedge clock);
      hold_off_now = 1;
      repeat (60) @(posedge clock);
      hold_off_now = 0;
   end

   // ---- request side ----
   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      bit          typed;
      logic [31:0] sum_want;
      logic [31:0] min_want;
   } table_row_type;

   table_row_type directed_rows[] = '{
      '{32'h0000_0000, 32'h8000_0000, 1, 32'h0000_0000, 32'h8000_0000},
      '{32'h8000_0000, 32'h3F80_0000, 1, 32'h0000_0000, 32'h8000_0000},
      '{32'h7F80_0000, 32'h3F80_0000, 1, 32'h7FC0_0000, 32'h3F80_0000},
      '{32'hFF80_0000, 32'h3F80_0000, 1, 32'h7FC0_0000, 32'hFF80_0000},
      '{32'h7FC0_0001, 32'h3F80_0000, 1, 32'h7FC0_0000, 32'h7FC0_0000},
      '{32'h3F80_0000, 32'hFFFF_FFFF, 1, 32'h7FC0_0000, 32'h7FC0_0000},
      '{32'h0000_0001, 32'h3F80_0000, 1, 32'h3F80_0000, 32'h0000_0001},
      '{32'h807F_FFFF, 32'h0000_0001, 1, 32'h0000_0000, 32'h807F_FFFF},
      '{32'h3F80_0000, 32'h007F_FFFF, 1, 32'h3F80_0000, 32'h007F_FFFF},
      '{32'h3F80_0000, 32'h3F80_0000, 1, 32'h4000_0000, 32'h3F80_0000},
      '{32'h3F80_0000, 32'hBF80_0000, 1, 32'h0000_0000, 32'hBF80_0000},
      '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1, 32'h7F80_0000, 32'h7F7F_FFFF},
      '{32'hFF7F_FFFF, 32'hFF7F_FFFF, 1, 32'hFF80_0000, 32'hFF7F_FFFF},
      '{32'h0080_0001, 32'h8080_0000, 0, 0, 0},
      '{32'h0080_0000, 32'h8080_0001, 0, 0, 0},
      '{32'h3F80_0000, 32'h3380_0000, 0, 0, 0},
      '{32'h3F80_0001, 32'h3380_0000, 0, 0, 0},
      '{32'h3F80_0000, 32'h0080_0000, 0, 0, 0},
      '{32'h7F00_0000, 32'h0080_0000, 0, 0, 0},
      '{32'hC000_0000, 32'hBFFF_FFFF, 0, 0, 0},
      '{32'h4B7F_FFFF, 32'h3F00_0000, 0, 0, 0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0}
   };

   function automatic logic [31:0] random_operand();
      logic [31:0] x;
      x = $urandom();
      case ($urandom_range(0, 9))
         0: x[30:23] = 8'h00;
         1: x[30:23] = 8'hFF;
         2: x[30:23] = $urandom_range(0, 1) ? 8'hFE : 8'h01;
         3: x[30:0] = 31'd0;
         default: x[30:23] = 8'($urandom_range(1, 254));
      endcase
      return x;
   endfunction

   // returns at the accepting edge with valid still high
   task automatic send_request(req_type rq);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (hold_off_now) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= rq;
      expected_rsp_q.push_back(predict_rsp(rq));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      req_type rq;
      rsp_type pred;
      logic [31:0] wa;
      reset <= 1;
      req_valid <= 0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         rq.a_bits = directed_rows[i].a;
         rq.b_bits = directed_rows[i].b;
         pred = predict_rsp(rq);
         if (directed_rows[i].typed &&
             (pred.sum_bits !== directed_rows[i].sum_want ||
              pred.min_bits !== directed_rows[i].min_want)) begin
            $display("table row %0d disagrees with predictor", i);
            error_count++;
         end
         send_request(rq);
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 250) begin
            // pause until the pipeline drains
            req_valid <= 0;
            @(posedge clock);
            while (expected_rsp_q.size() != 0) @(posedge clock);
         end
         wa = random_operand();
         rq.a_bits = wa;
         case ($urandom_range(0, 4))
            0: rq.b_bits = wa ^ 32'h8000_0000;
            1: rq.b_bits = {wa[31:23] - 9'($urandom_range(0, 30)), 23'($urandom())};
            default: rq.b_bits = random_operand();
         endcase
         send_request(rq);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH * 4) @(posedge clock);
      $display("covered %0d responses: zeros, infinities, NaNs, subnormals, overflow,",
               rsp_count);
      $display("cancellation and rounding, with random stalls on both channels");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
